// ===== src/vcsm_pkg.sv =====
package vcsm_pkg;

  localparam int COORD_W      = 6;
  localparam int OUT_W        = 7;
  localparam int TRI_COUNT    = 12;
  localparam int TRI_W        = 4;
  localparam int GRID_DIM_DEF = 64;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_EMIT
  } state_t;

  // which map row the sequencer is looking at
  typedef enum logic [2:0] {
    PR_CENTRE,
    PR_Y_DN,
    PR_Y_UP,
    PR_Z_DN,
    PR_Z_UP
  } probe_t;

  // corner indices of one triangle, first corner in the top bits
  function automatic logic [8:0] tri_corners(input logic [TRI_W-1:0] t);
    logic [8:0] r;
    case (t)
      4'd0:    r = {3'd0, 3'd1, 3'd4};
      4'd1:    r = {3'd1, 3'd2, 3'd5};
      4'd2:    r = {3'd2, 3'd3, 3'd6};
      4'd3:    r = {3'd3, 3'd0, 3'd7};
      4'd4:    r = {3'd4, 3'd5, 3'd1};
      4'd5:    r = {3'd5, 3'd6, 3'd2};
      4'd6:    r = {3'd6, 3'd7, 3'd3};
      4'd7:    r = {3'd7, 3'd0, 3'd4};
      4'd8:    r = {3'd0, 3'd1, 3'd2};
      4'd9:    r = {3'd0, 3'd3, 3'd2};
      4'd10:   r = {3'd4, 3'd5, 3'd6};
      4'd11:   r = {3'd4, 3'd7, 3'd6};
      default: r = '0;
    endcase
    return r;
  endfunction

  // corners 2 and 3 of a level sit at x+1
  function automatic logic corner_dx(input logic [2:0] k);
    return k[1];
  endfunction

  // corners 1 and 2 of a level sit at y+1
  function automatic logic corner_dy(input logic [2:0] k);
    return k[1] ^ k[0];
  endfunction

  function automatic logic corner_dz(input logic [2:0] k);
    return k[2];
  endfunction

endpackage

// ===== src/voxel_cube_surface_mesher.sv =====
// Voxel occupancy map with surface query. The map is held as one row word of GRID_DIM bits
// per (y, z) pair in a single-port-read memory; after reset a clearing pass writes one row a
// cycle through every row of the memory and in_ready stays low until it ends. A load word
// reads its row, then writes it back with the bit changed. A query reads the voxel's row
// (which also holds its x neighbours) and then at most four more rows for the y and z
// neighbours, each row read passing through ST_READ and ST_CHECK; a surface voxel then gives
// its 12 triangles one word per cycle while out_ready is high, last_triangle marking the
// twelfth. The block takes one word at a time: in_ready is high only when it is idle.
module voxel_cube_surface_mesher #(
  parameter int GRID_DIM = vcsm_pkg::GRID_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [vcsm_pkg::COORD_W-1:0] voxel_x,
  input  logic [vcsm_pkg::COORD_W-1:0] voxel_y,
  input  logic [vcsm_pkg::COORD_W-1:0] voxel_z,
  input  logic                       occupied,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [vcsm_pkg::OUT_W-1:0] first_x,
  output logic [vcsm_pkg::OUT_W-1:0] first_y,
  output logic [vcsm_pkg::OUT_W-1:0] first_z,
  output logic [vcsm_pkg::OUT_W-1:0] second_x,
  output logic [vcsm_pkg::OUT_W-1:0] second_y,
  output logic [vcsm_pkg::OUT_W-1:0] second_z,
  output logic [vcsm_pkg::OUT_W-1:0] third_x,
  output logic [vcsm_pkg::OUT_W-1:0] third_y,
  output logic [vcsm_pkg::OUT_W-1:0] third_z,
  output logic                       last_triangle
);
  import vcsm_pkg::*;

  localparam int CW    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int RW    = 2 * CW;
  localparam int ROWS  = 2 ** RW;
  localparam int LIM_W = COORD_W + CW;

  state_t             state, state_next;
  probe_t             probe, probe_next;
  logic [TRI_W-1:0]   tri_idx, tri_next;
  logic [RW-1:0]      clr, clr_next;

  logic               req_r;
  logic               occ_r;
  logic [COORD_W-1:0] x_r, y_r, z_r;

  logic [GRID_DIM-1:0] mem [ROWS];
  logic [GRID_DIM-1:0] rd_data;
  logic [RW-1:0]       rd_addr;
  logic                mem_we;
  logic [RW-1:0]       wr_addr;
  logic [GRID_DIM-1:0] wr_data;

  logic [CW-1:0] xc, yc, zc, xp, xm, yp, ym, zp, zm;
  logic          in_grid;
  logic          border;
  logic          hit;
  logic [8:0]    tri_k;
  logic [2:0]    k0, k1, k2;

  assign xc = CW'(x_r);
  assign yc = CW'(y_r);
  assign zc = CW'(z_r);
  assign xp = xc + 1'b1;
  assign xm = xc - 1'b1;
  assign yp = yc + 1'b1;
  assign ym = yc - 1'b1;
  assign zp = zc + 1'b1;
  assign zm = zc - 1'b1;

  assign in_grid = (LIM_W'(voxel_x) < LIM_W'(GRID_DIM)) &&
                   (LIM_W'(voxel_y) < LIM_W'(GRID_DIM)) &&
                   (LIM_W'(voxel_z) < LIM_W'(GRID_DIM));

  assign border = (x_r == '0) || (y_r == '0) || (z_r == '0) ||
                  (LIM_W'(x_r) == LIM_W'(GRID_DIM - 1)) ||
                  (LIM_W'(y_r) == LIM_W'(GRID_DIM - 1)) ||
                  (LIM_W'(z_r) == LIM_W'(GRID_DIM - 1));

  // the one compare the sequencer keeps reusing: the voxel's column in the row just read
  assign hit = rd_data[xc];

  always_comb begin
    case (probe)
      PR_CENTRE: rd_addr = {zc, yc};
      PR_Y_DN:   rd_addr = {zc, ym};
      PR_Y_UP:   rd_addr = {zc, yp};
      PR_Z_DN:   rd_addr = {zm, yc};
      PR_Z_UP:   rd_addr = {zp, yc};
      default:   rd_addr = {zc, yc};
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_r <= req_type;
      occ_r <= occupied;
      x_r   <= voxel_x;
      y_r   <= voxel_y;
      z_r   <= voxel_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      probe   <= PR_CENTRE;
      tri_idx <= '0;
      clr     <= '0;
    end else begin
      state   <= state_next;
      probe   <= probe_next;
      tri_idx <= tri_next;
      clr     <= clr_next;
    end
  end

  always_comb begin
    state_next = state;
    probe_next = probe;
    tri_next   = tri_idx;
    clr_next   = clr;
    mem_we     = 1'b0;
    wr_addr    = {zc, yc};
    wr_data    = rd_data;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        wr_addr  = clr;
        wr_data  = '0;
        clr_next = clr + 1'b1;
        if (clr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        probe_next = PR_CENTRE;
        if (in_valid && in_grid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        case (probe)
          PR_CENTRE: begin
            if (req_r == REQ_LOAD) begin
              mem_we      = 1'b1;
              wr_data[xc] = occ_r;
              state_next  = ST_IDLE;
            end else if (!hit) begin
              state_next = ST_IDLE;
            end else if (border || !(rd_data[xp] && rd_data[xm])) begin
              tri_next   = '0;
              state_next = ST_EMIT;
            end else begin
              probe_next = PR_Y_DN;
              state_next = ST_READ;
            end
          end
          default: begin
            if (!hit) begin
              tri_next   = '0;
              state_next = ST_EMIT;
            end else begin
              state_next = ST_READ;
              case (probe)
                PR_Y_DN: probe_next = PR_Y_UP;
                PR_Y_UP: probe_next = PR_Z_DN;
                PR_Z_DN: probe_next = PR_Z_UP;
                default: state_next = ST_IDLE; // all six neighbours filled: interior
              endcase
            end
          end
        endcase
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (tri_idx == TRI_W'(TRI_COUNT - 1)) begin
            state_next = ST_IDLE;
          end else begin
            tri_next = tri_idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign tri_k = tri_corners(tri_idx);
  assign k0    = tri_k[8:6];
  assign k1    = tri_k[5:3];
  assign k2    = tri_k[2:0];

  assign first_x  = OUT_W'(x_r) + OUT_W'(corner_dx(k0));
  assign first_y  = OUT_W'(y_r) + OUT_W'(corner_dy(k0));
  assign first_z  = OUT_W'(z_r) + OUT_W'(corner_dz(k0));
  assign second_x = OUT_W'(x_r) + OUT_W'(corner_dx(k1));
  assign second_y = OUT_W'(y_r) + OUT_W'(corner_dy(k1));
  assign second_z = OUT_W'(z_r) + OUT_W'(corner_dz(k1));
  assign third_x  = OUT_W'(x_r) + OUT_W'(corner_dx(k2));
  assign third_y  = OUT_W'(y_r) + OUT_W'(corner_dy(k2));
  assign third_z  = OUT_W'(z_r) + OUT_W'(corner_dz(k2));

  assign last_triangle = (tri_idx == TRI_W'(TRI_COUNT - 1));

endmodule

// ===== src/vcsm_checker.sv =====
module vcsm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [vcsm_pkg::OUT_W-1:0] first_x,
  input logic                       last_triangle
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_x) && $stable(last_triangle))
    else $error("output word changed while stalled");

  // no new word taken while triangles are still going out
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready during triangle output");

  // a run of triangles does not break before its last word
  a_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_triangle |=> out_valid)
    else $error("triangle run broken early");

  // and ends right after it
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_triangle |=> !out_valid)
    else $error("output continued past last triangle");

endmodule

bind voxel_cube_surface_mesher vcsm_checker u_vcsm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .first_x       (first_x),
  .last_triangle (last_triangle)
);
